/* sv/slcb_pkg.sv */
// shared constants, tables and types for the soft light color blend pipeline
`default_nettype none

package slcb_pkg;

    // fraction bits of the fixed point channel values
    localparam int FRAC_BITS = 16;

    localparam int PIX_W     = 8;
    localparam int OP_W      = 9;
    localparam int OP_FULL   = 256;
    localparam int OPW_W     = 16;                 // width of 255 * opacity
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = OP_W;

    localparam int X_W  = FRAC_BITS + 1;           // x and sqrt(x), 0 .. 1.0
    localparam int F_W  = X_W + 2;                 // signed soft light term
    localparam int M_W  = F_W - 1 + PIX_W;         // |k| * |f|
    localparam int RCP_SHIFT = 24;                 // m / 255 ~ (m * 0x10101) >> 24
    localparam int Q_W  = M_W - 7;                 // quotient of m / 255
    localparam int C_W  = Q_W + 2;                 // signed blended value
    localparam int P_W  = C_W + OPW_W + 1;         // c * 255 * op
    localparam int N_W  = P_W + 1;                 // mixed numerator
    localparam int OUT_SHIFT = FRAC_BITS + 8;

    localparam int STAGES = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TINT_BLUE  = 4'd0,
        REG_TINT_GREEN = 4'd1,
        REG_TINT_RED   = 4'd2,
        REG_OPACITY    = 4'd3
    } cfg_reg_t;

    typedef logic [255:0][X_W-1:0] chan_tab_t;

    // opacity derived terms; the user must keep them static while pixels flow, the block does not enforce it
    typedef struct packed {
        logic [OPW_W-1:0] op_w;    // 255 * op
        logic [OP_W-1:0]  op_inv;  // 256 - op
    } blend_cfg_t;

    // stage advance enables and the mask flag of the item entering the last stage
    typedef struct packed {
        logic [STAGES-1:0] adv;
        logic              mask_s6;
    } pipe_ctrl_t;

    function automatic longint unsigned isqrt64(longint unsigned v);
        longint unsigned rem;
        longint unsigned res;
        longint unsigned bitv;
        rem  = v;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // x = round(p * 2^FRAC / 255)
    function automatic chan_tab_t build_x_tab();
        chan_tab_t       t;
        longint unsigned v;
        for (int i = 0; i < 256; i++) begin
            v    = ((longint'(i) << FRAC_BITS) + 127) / 255;
            t[i] = v[X_W-1:0];
        end
        return t;
    endfunction

    // floor(sqrt(p / 255) * 2^FRAC)
    function automatic chan_tab_t build_sqrt_tab();
        chan_tab_t       t;
        longint unsigned v;
        for (int i = 0; i < 256; i++) begin
            v    = isqrt64((longint'(i) << (2 * FRAC_BITS)) / 255);
            t[i] = v[X_W-1:0];
        end
        return t;
    endfunction

    localparam chan_tab_t X_TAB    = build_x_tab();
    localparam chan_tab_t SQRT_TAB = build_sqrt_tab();

endpackage

`default_nettype wire

/* sv/slcb_cfg_regs.sv */
// configuration registers: tint color and opacity
`default_nettype none

module slcb_cfg_regs
    import slcb_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data,
    output logic      [PIX_W-1:0]     tint_blue,
    output logic      [PIX_W-1:0]     tint_green,
    output logic      [PIX_W-1:0]     tint_red,
    output blend_cfg_t                bcfg
);

    logic [PIX_W-1:0] tint_blue_reg, tint_blue_next;
    logic [PIX_W-1:0] tint_green_reg, tint_green_next;
    logic [PIX_W-1:0] tint_red_reg, tint_red_next;
    logic [OP_W-1:0]  opacity_reg, opacity_next;
    logic [OP_W-1:0]  op_clamped;
    logic [OP_W+PIX_W-1:0] op_x255;

    assign cfg_ready = 1'b1;

    always_comb begin
        tint_blue_next  = tint_blue_reg;
        tint_green_next = tint_green_reg;
        tint_red_next   = tint_red_reg;
        opacity_next    = opacity_reg;
        if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_TINT_BLUE:  tint_blue_next  = cfg_data[PIX_W-1:0];
                REG_TINT_GREEN: tint_green_next = cfg_data[PIX_W-1:0];
                REG_TINT_RED:   tint_red_next   = cfg_data[PIX_W-1:0];
                REG_OPACITY:    opacity_next    = cfg_data[OP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tint_blue_reg  <= PIX_W'(51);
            tint_green_reg <= PIX_W'(51);
            tint_red_reg   <= PIX_W'(204);
            opacity_reg    <= OP_W'(205);
        end else begin
            tint_blue_reg  <= tint_blue_next;
            tint_green_reg <= tint_green_next;
            tint_red_reg   <= tint_red_next;
            opacity_reg    <= opacity_next;
        end
    end

    // opacity above full counts as full
    assign op_clamped = (opacity_reg > OP_W'(OP_FULL)) ? OP_W'(OP_FULL) : opacity_reg;
    assign op_x255    = {op_clamped, {PIX_W{1'b0}}} - (OP_W+PIX_W)'(op_clamped);

    assign tint_blue   = tint_blue_reg;
    assign tint_green  = tint_green_reg;
    assign tint_red    = tint_red_reg;
    assign bcfg.op_w   = op_x255[OPW_W-1:0];
    assign bcfg.op_inv = OP_W'(OP_FULL) - op_clamped;

endmodule

`default_nettype wire

/* sv/slcb_chan.sv */
// seven stage soft light datapath for one color channel
`default_nettype none

module slcb_chan
    import slcb_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic [PIX_W-1:0] pix,
    input  wire logic [PIX_W-1:0] tint,
    input  wire blend_cfg_t       bcfg,
    input  wire pipe_ctrl_t       ctrl,
    output logic      [PIX_W-1:0] res
);

    // stage 1: table lookups
    logic [X_W-1:0]   x1_reg, sq1_reg;
    logic [PIX_W-1:0] p1_reg;
    // stage 2: soft light term
    logic signed [F_W-1:0] f2_reg, f2_next;
    logic [X_W-1:0]   x2_reg;
    logic [PIX_W-1:0] p2_reg;
    // stage 3: |k * f|
    logic [M_W-1:0]   m3_reg, m3_next;
    logic             neg3_reg, neg3_next;
    logic [X_W-1:0]   x3_reg;
    logic [PIX_W-1:0] p3_reg;
    // stage 4: quotient estimate
    logic [Q_W-1:0]   q4_reg, q4_next;
    logic [M_W-1:0]   m4_reg;
    logic             neg4_reg;
    logic [X_W-1:0]   x4_reg;
    logic [PIX_W-1:0] p4_reg;
    // stage 5: blended value
    logic signed [C_W-1:0] c5_reg, c5_next;
    logic [PIX_W-1:0] p5_reg;
    // stage 6: opacity products
    logic signed [P_W-1:0] prod6_reg, prod6_next;
    logic [PIX_W+OP_W-1:0] base6_reg, base6_next;
    logic [PIX_W-1:0] p6_reg;
    // stage 7: result
    logic [PIX_W-1:0] res7_reg, res7_next;

    logic [2*X_W-1:0]       xx;
    logic [PIX_W-1:0]       kabs;
    logic                   kneg;
    logic [F_W-1:0]         fabs;
    logic [M_W+16:0]        rsum;
    logic [M_W-1:0]         q255;
    logic [M_W-1:0]         rem;
    logic [Q_W-1:0]         q;
    logic signed [N_W-1:0]  num;
    logic [N_W-OUT_SHIFT-2:0] hi;

    // soft light term: x - x^2 for dark tints, sqrt(x) - x for light ones
    always_comb begin
        xx = x1_reg * x1_reg;
        if (tint <= PIX_W'(128))
            f2_next = $signed({2'b00, x1_reg}) - $signed({1'b0, xx[2*X_W-1:FRAC_BITS]});
        else
            f2_next = $signed({2'b00, sq1_reg}) - $signed({2'b00, x1_reg});
    end

    // k = 2L - 255; its magnitude is odd and it is negative when the tint msb is clear
    always_comb begin
        kneg      = ~tint[PIX_W-1];
        kabs      = {(tint[PIX_W-1] ? tint[PIX_W-2:0] : ~tint[PIX_W-2:0]), 1'b1};
        fabs      = f2_reg[F_W-1] ? F_W'(-f2_reg) : F_W'(f2_reg);
        m3_next   = kabs * fabs[F_W-2:0];
        neg3_next = kneg ^ f2_reg[F_W-1];
    end

    // m / 255 estimate, low by at most one
    always_comb begin
        rsum    = (M_W+17)'(m3_reg) + ((M_W+17)'(m3_reg) << 8) + ((M_W+17)'(m3_reg) << 16);
        q4_next = rsum[RCP_SHIFT +: Q_W];
    end

    // one step correction then truncate toward zero by sign
    always_comb begin
        q255 = M_W'({q4_reg, 8'b0}) - M_W'(q4_reg);
        rem  = m4_reg - q255;
        q    = (rem >= M_W'(255)) ? q4_reg + Q_W'(1) : q4_reg;
        if (neg4_reg)
            c5_next = $signed(C_W'(x4_reg)) - $signed(C_W'(q));
        else
            c5_next = $signed(C_W'(x4_reg)) + $signed(C_W'(q));
    end

    always_comb begin
        prod6_next = P_W'(c5_reg * $signed({1'b0, bcfg.op_w}));
        base6_next = p5_reg * bcfg.op_inv;
    end

    // mix, floor at zero, saturate at full scale; unmasked pixels pass through unchanged
    always_comb begin
        num = N_W'(prod6_reg) + $signed(N_W'({base6_reg, {FRAC_BITS{1'b0}}}));
        hi  = num[N_W-2:OUT_SHIFT];
        if (!ctrl.mask_s6)
            res7_next = p6_reg;
        else if (num[N_W-1])
            res7_next = '0;
        else if (hi > (N_W-OUT_SHIFT-1)'(255))
            res7_next = PIX_W'(255);
        else
            res7_next = hi[PIX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.adv[0]) begin
            x1_reg  <= X_TAB[pix];
            sq1_reg <= SQRT_TAB[pix];
            p1_reg  <= pix;
        end
        if (ctrl.adv[1]) begin
            f2_reg <= f2_next;
            x2_reg <= x1_reg;
            p2_reg <= p1_reg;
        end
        if (ctrl.adv[2]) begin
            m3_reg   <= m3_next;
            neg3_reg <= neg3_next;
            x3_reg   <= x2_reg;
            p3_reg   <= p2_reg;
        end
        if (ctrl.adv[3]) begin
            q4_reg   <= q4_next;
            m4_reg   <= m3_reg;
            neg4_reg <= neg3_reg;
            x4_reg   <= x3_reg;
            p4_reg   <= p3_reg;
        end
        if (ctrl.adv[4]) begin
            c5_reg <= c5_next;
            p5_reg <= p4_reg;
        end
        if (ctrl.adv[5]) begin
            prod6_reg <= prod6_next;
            base6_reg <= base6_next;
            p6_reg    <= p5_reg;
        end
        if (ctrl.adv[6]) begin
            res7_reg <= res7_next;
        end
    end

    assign res = res7_reg;

endmodule

`default_nettype wire

/* sv/soft_light_color_blend.sv */
// top level of the soft light color blend: stream ports, valid pipeline, three channels
`default_nettype none

// Soft light tint blend, one BGR pixel per transaction. A pixel whose mask
// flag (s_tuser) is clear comes out unchanged; a masked pixel is blended per
// channel with the tint color by soft light, mixed with the original by the
// opacity in 1/256 units, truncated and clamped to 0..255. The datapath is a
// seven stage pipeline (table lookup, soft light term, tint scale, divide by
// 255 estimate, correction, opacity multiply, mix and clamp), and a new pixel
// is taken in every cycle unless the output stalls. Each stage moves on when
// it is empty or the stage after it moves, so s_tready drops only when all
// seven stages hold pixels and m_tready is low. Tint and opacity are
// written through the cfg port; they must only be changed while the
// pipeline is empty.

module soft_light_color_blend
    import slcb_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration write channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data,
    // pixel input
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [23:0]          s_tdata,   // pix_blue, pix_green, pix_red
    input  wire logic [0:0]           s_tuser,   // inside_mask
    // pixel output
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [23:0]          m_tdata    // res_blue, res_green, res_red
);

    logic [PIX_W-1:0]  tint_blue, tint_green, tint_red;
    blend_cfg_t        bcfg;
    pipe_ctrl_t        ctrl;
    logic [STAGES-1:0] valid_reg, valid_next;
    logic [STAGES-1:0] mask_reg, mask_next;
    logic [STAGES-1:0] adv;

    slcb_cfg_regs u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .tint_blue  (tint_blue),
        .tint_green (tint_green),
        .tint_red   (tint_red),
        .bcfg       (bcfg)
    );

    // a stage advances when empty or when the next one advances
    always_comb begin
        adv[STAGES-1] = !valid_reg[STAGES-1] || m_tready;
        for (int i = STAGES-2; i >= 0; i--)
            adv[i] = !valid_reg[i] || adv[i+1];
    end

    always_comb begin
        valid_next = valid_reg;
        mask_next  = mask_reg;
        if (adv[0]) begin
            valid_next[0] = s_tvalid;
            mask_next[0]  = s_tuser[0];
        end
        for (int i = 1; i < STAGES; i++) begin
            if (adv[i]) begin
                valid_next[i] = valid_reg[i-1];
                mask_next[i]  = mask_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            mask_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            mask_reg  <= mask_next;
        end
    end

    assign ctrl.adv     = adv;
    assign ctrl.mask_s6 = mask_reg[STAGES-2];

    assign s_tready = adv[0];
    assign m_tvalid = valid_reg[STAGES-1];

    slcb_chan u_blue (
        .aclk (aclk),
        .pix  (s_tdata[7:0]),
        .tint (tint_blue),
        .bcfg (bcfg),
        .ctrl (ctrl),
        .res  (m_tdata[7:0])
    );

    slcb_chan u_green (
        .aclk (aclk),
        .pix  (s_tdata[15:8]),
        .tint (tint_green),
        .bcfg (bcfg),
        .ctrl (ctrl),
        .res  (m_tdata[15:8])
    );

    slcb_chan u_red (
        .aclk (aclk),
        .pix  (s_tdata[23:16]),
        .tint (tint_red),
        .bcfg (bcfg),
        .ctrl (ctrl),
        .res  (m_tdata[23:16])
    );

endmodule

`default_nettype wire
